>>> hw/rtl/plra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plra_pkg
// Shared widths, constants and types of the packet loss rate adapter.
// ----------------------------------------------------------------------------
package plra_pkg;

	localparam int unsigned WINDOW    = 5;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned SUM_W     = CNT_W + $clog2(WINDOW);
	localparam int unsigned OUT_SUM_W = 35;
	localparam int unsigned LVL_W     = 2;

	localparam int unsigned LIMIT_W   = 7;
	localparam logic [LIMIT_W-1:0] LOSS_LIMIT = LIMIT_W'(99);
	localparam int unsigned M99_W     = SUM_W + LIMIT_W;

	localparam logic [CNT_W-1:0] MAX_RATE_RESET = CNT_W'(115000000);
	localparam logic [CNT_W-1:0] MIN_RATE_RESET = CNT_W'(115000000 / 1000);

	// floor(x / 1000) = (x * LO_DIV_MAGIC) >> LO_DIV_SHIFT for any 32-bit x
	localparam logic [CNT_W-1:0] LO_DIV_MAGIC = CNT_W'(274877907);
	localparam int unsigned      LO_DIV_SHIFT = 38;

	// floor(x / 5) = (x * DIV5_MAGIC) >> DIV5_SHIFT for any 32-bit x
	localparam logic [CNT_W-1:0] DIV5_MAGIC = 32'hCCCC_CCCD;
	localparam int unsigned      DIV5_SHIFT = 34;
	localparam int unsigned      Q_W        = 2 * CNT_W - DIV5_SHIFT;

	typedef enum logic [LVL_W-1:0] {
		LVL_CLEAN  = 2'd0,
		LVL_MINOR  = 2'd1,
		LVL_SEVERE = 2'd2
	} level_t;

	typedef enum logic [1:0] {
		DIR_HOLD,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef struct packed {
		logic [CNT_W-1:0] rx;
		logic [CNT_W-1:0] ms;
	} delta_t;

endpackage

>>> hw/rtl/plra_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plra_if
// Request and report channels of the packet loss rate adapter.
// ----------------------------------------------------------------------------
interface plra_req_if import plra_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] received_count;
	logic [CNT_W-1:0] missed_count;
	logic [CNT_W-1:0] current_rate;

	modport source (output valid, received_count, missed_count, current_rate, input ready);
	modport sink   (input valid, received_count, missed_count, current_rate, output ready);
endinterface

interface plra_rpt_if import plra_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [LVL_W-1:0]     health_level;
	logic [OUT_SUM_W-1:0] recent_received;
	logic [OUT_SUM_W-1:0] recent_missed;
	logic [CNT_W-1:0]     new_rate;
	logic                 rate_changed;

	modport source (output valid, health_level, recent_received, recent_missed, new_rate,
		rate_changed, input ready);
	modport sink   (input valid, health_level, recent_received, recent_missed, new_rate,
		rate_changed, output ready);
endinterface

>>> hw/rtl/plra_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plra_cell
// One window slot: holds a received/missed delta pair and passes it on.
// ----------------------------------------------------------------------------
module plra_cell import plra_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  delta_t d,
	output delta_t q
);

	delta_t slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (en) begin
			slot_q <= d;
		end
	end

	assign q = slot_q;

endmodule

>>> hw/rtl/plra_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plra_adjust
// Health grading and rate adjustment pipeline with per-stage flow control.
// ----------------------------------------------------------------------------
module plra_adjust import plra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SUM_W-1:0] r_in,
	input  logic [SUM_W-1:0] m_in,
	input  logic [CNT_W-1:0] rate_in,
	input  logic [CNT_W-1:0] max_rate,
	input  logic [CNT_W-1:0] min_rate,
	plra_rpt_if.source       report
);

	logic v1_q, v2_q, v3_q, v4_q, vo_q;
	logic en1, en2, en3, en4, eno;

	logic [SUM_W-1:0] r_s1, m_s1, r_s2, m_s2, r_s3, m_s3, r_s4, m_s4;
	logic [CNT_W-1:0] rate_s1, rate_s2, rate_s3, rate_s4;
	logic [M99_W-1:0] m99_s2;
	level_t           level_s3, level_s4;
	dir_t             dir_s3, dir_s4;
	logic [CNT_W-1:0] w_s3;
	logic [Q_W-1:0]   q_s4;

	level_t             level_c;
	dir_t               dir_c;
	logic [CNT_W:0]     z_c;
	logic [2*CNT_W-1:0] prod_c;
	logic [CNT_W:0]     cand_c;
	logic [CNT_W-1:0]   hi_c;
	logic [CNT_W-1:0]   next_c;

	assign eno      = !vo_q || report.ready;
	assign en4      = !v4_q || eno;
	assign en3      = !v3_q || en4;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign in_ready = en1;

	always_comb begin
		priority if (m_s2 == '0) begin
			level_c = LVL_CLEAN;
		end else if (M99_W'(r_s2) > m99_s2) begin
			level_c = LVL_MINOR;
		end else begin
			level_c = LVL_SEVERE;
		end
		priority if (m_s2 == '0 && r_s2 != '0) begin
			dir_c = DIR_UP;
		end else if (M99_W'(r_s2) < m99_s2) begin
			dir_c = DIR_DOWN;
		end else begin
			dir_c = DIR_HOLD;
		end
		// up: rate + floor((rate + 5) / 10), down: rate - floor((rate + 4) / 10)
		z_c = {1'b0, rate_s2} + ((dir_c == DIR_UP) ? (CNT_W + 1)'(5) : (CNT_W + 1)'(4));
	end

	assign prod_c = (2 * CNT_W)'(w_s3) * (2 * CNT_W)'(DIV5_MAGIC);

	always_comb begin
		if (dir_s4 == DIR_UP) begin
			cand_c = {1'b0, rate_s4} + (CNT_W + 1)'(q_s4);
		end else begin
			cand_c = {1'b0, rate_s4} - (CNT_W + 1)'(q_s4);
		end
		hi_c = (cand_c > {1'b0, max_rate}) ? max_rate : cand_c[CNT_W-1:0];
		if (dir_s4 == DIR_HOLD) begin
			next_c = rate_s4;
		end else begin
			next_c = (hi_c < min_rate) ? min_rate : hi_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1) v1_q <= in_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (eno) vo_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1    <= r_in;
			m_s1    <= m_in;
			rate_s1 <= rate_in;
		end
		if (en2) begin
			r_s2    <= r_s1;
			m_s2    <= m_s1;
			rate_s2 <= rate_s1;
			m99_s2  <= M99_W'(m_s1) * M99_W'(LOSS_LIMIT);
		end
		if (en3) begin
			r_s3     <= r_s2;
			m_s3     <= m_s2;
			rate_s3  <= rate_s2;
			level_s3 <= level_c;
			dir_s3   <= dir_c;
			w_s3     <= z_c[CNT_W:1];
		end
		if (en4) begin
			r_s4     <= r_s3;
			m_s4     <= m_s3;
			rate_s4  <= rate_s3;
			level_s4 <= level_s3;
			dir_s4   <= dir_s3;
			q_s4     <= prod_c[2*CNT_W-1:DIV5_SHIFT];
		end
		if (eno) begin
			report.health_level    <= level_s4;
			report.recent_received <= OUT_SUM_W'(r_s4);
			report.recent_missed   <= OUT_SUM_W'(m_s4);
			report.new_rate        <= next_c;
			report.rate_changed    <= (next_c != rate_s4);
		end
	end

	assign report.valid = vo_q;

endmodule

>>> hw/rtl/packet_loss_rate_adapter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_loss_rate_adapter_unit
// Windowed packet loss grading and stream rate adjustment.
// ----------------------------------------------------------------------------
// One request per monitoring period carries the cumulative received and missed
// counters and the rate in effect; each request gives exactly one report. A
// request is taken every cycle unless the pipeline stalls; its report comes
// out through the five adjust registers (window update, loss multiply,
// grading, divide-by-ten multiply, clamp and output). Each pipeline stage
// stalls on its own, so requests keep entering while an earlier report
// waits, until every stage is full. The window is a chain of WINDOW cells
// shifting one place per request; min_rate_q follows max_rate_q next cycle.
module packet_loss_rate_adapter_unit import plra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	plra_req_if.sink         counts,
	plra_rpt_if.source       report
);

	logic             accept;
	logic [CNT_W-1:0] max_rate_q;
	logic [CNT_W-1:0] min_rate_q;
	logic [2*CNT_W-1:0] lo_prod;
	delta_t           prev_q;
	delta_t           delta;
	delta_t           cell_d [WINDOW];
	delta_t           cell_q [WINDOW];
	logic [SUM_W-1:0] rx_sum_q, ms_sum_q;
	logic [SUM_W-1:0] rx_sum_next, ms_sum_next;

	assign accept   = counts.valid && counts.ready;
	assign delta.rx = counts.received_count - prev_q.rx;
	assign delta.ms = counts.missed_count - prev_q.ms;
	assign lo_prod  = (2 * CNT_W)'(max_rate_q) * (2 * CNT_W)'(LO_DIV_MAGIC);

	assign rx_sum_next = rx_sum_q - SUM_W'(cell_q[WINDOW-1].rx) + SUM_W'(delta.rx);
	assign ms_sum_next = ms_sum_q - SUM_W'(cell_q[WINDOW-1].ms) + SUM_W'(delta.ms);

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign cell_d[i] = delta;
		end else begin : g_link
			assign cell_d[i] = cell_q[i-1];
		end
		plra_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.d      (cell_d[i]),
			.q      (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rate_q <= MAX_RATE_RESET;
			min_rate_q <= MIN_RATE_RESET;
			prev_q     <= '0;
			rx_sum_q   <= '0;
			ms_sum_q   <= '0;
		end else begin
			if (cfg_we) max_rate_q <= cfg_wdata;
			min_rate_q <= CNT_W'(lo_prod[2*CNT_W-1:LO_DIV_SHIFT]);
			if (accept) begin
				prev_q.rx <= counts.received_count;
				prev_q.ms <= counts.missed_count;
				rx_sum_q  <= rx_sum_next;
				ms_sum_q  <= ms_sum_next;
			end
		end
	end

	plra_adjust u_adjust (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (counts.valid),
		.in_ready (counts.ready),
		.r_in     (rx_sum_next),
		.m_in     (ms_sum_next),
		.rate_in  (counts.current_rate),
		.max_rate (max_rate_q),
		.min_rate (min_rate_q),
		.report   (report)
	);

endmodule

>>> hw/rtl/plra_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plra_checker
// Port-level checks of the packet loss rate adapter reports.
// ----------------------------------------------------------------------------
module plra_checker import plra_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rpt_valid,
	input logic                 rpt_ready,
	input logic [LVL_W-1:0]     health_level,
	input logic [OUT_SUM_W-1:0] recent_received,
	input logic [OUT_SUM_W-1:0] recent_missed,
	input logic [CNT_W-1:0]     new_rate,
	input logic                 rate_changed
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=> rpt_valid && $stable(new_rate) &&
			$stable(health_level) && $stable(recent_received) && $stable(recent_missed))
		else $error("report dropped or changed while stalled");

	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> ((recent_missed == '0) == (health_level == LVL_CLEAN)))
		else $error("health level disagrees with missed sum");

	a_minor: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && health_level == LVL_MINOR |-> recent_received > recent_missed)
		else $error("minor loss reported without enough received packets");

	a_raise: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && rate_changed && health_level == LVL_CLEAN |-> recent_received != '0)
		else $error("rate changed on an empty window");

endmodule

bind packet_loss_rate_adapter_unit plra_checker u_plra_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rpt_valid       (report.valid),
	.rpt_ready       (report.ready),
	.health_level    (report.health_level),
	.recent_received (report.recent_received),
	.recent_missed   (report.recent_missed),
	.new_rate        (report.new_rate),
	.rate_changed    (report.rate_changed)
);

>>> test/tb_packet_loss_rate_adapter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_loss_rate_adapter_unit
// Self-checking bench for the packet loss rate adapter: counter snapshots go
// in with random gaps, reports come out under random back-pressure, and every
// report is matched in order against a software copy of the window sums,
// health grading and rate clamp, over several max_rate settings.
// ----------------------------------------------------------------------------
module tb_packet_loss_rate_adapter_unit;
	import plra_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned ITEMS_PER_SETTING = 100;
	localparam int unsigned REPORT_LATENCY = 4;
	localparam int unsigned MAX_SHOWN = 10;

	class health_scoreboard;
		typedef struct {
			level_t               lvl;
			logic [OUT_SUM_W-1:0] recent_rx;
			logic [OUT_SUM_W-1:0] recent_ms;
			logic [CNT_W-1:0]     rate;
			logic                 changed;
		} report_t;

		logic [CNT_W-1:0] max_rate;
		logic [CNT_W-1:0] prev_rx;
		logic [CNT_W-1:0] prev_ms;
		logic [CNT_W-1:0] rx_win [WINDOW];
		logic [CNT_W-1:0] ms_win [WINDOW];
		int unsigned      slot;
		logic [63:0]      rx_sum;
		logic [63:0]      ms_sum;
		report_t          pending_reports[$];
		int unsigned      mismatches;

		function new();
			max_rate = MAX_RATE_RESET;
			prev_rx = '0;
			prev_ms = '0;
			foreach (rx_win[i]) begin
				rx_win[i] = '0;
				ms_win[i] = '0;
			end
			slot = 0;
			rx_sum = '0;
			ms_sum = '0;
			mismatches = 0;
		endfunction

		function int unsigned pending();
			return pending_reports.size();
		endfunction

		// advance the window with one accepted request and queue its report
		function void take_request(logic [CNT_W-1:0] rx, logic [CNT_W-1:0] ms,
				logic [CNT_W-1:0] rate);
			logic [CNT_W-1:0] drx;
			logic [CNT_W-1:0] dms;
			logic [63:0]      limit;
			logic [63:0]      next_rate;
			logic [63:0]      floor_rate;
			report_t          rpt;
			drx = rx - prev_rx;
			dms = ms - prev_ms;
			rx_sum = rx_sum - {32'b0, rx_win[slot]} + {32'b0, drx};
			ms_sum = ms_sum - {32'b0, ms_win[slot]} + {32'b0, dms};
			rx_win[slot] = drx;
			ms_win[slot] = dms;
			slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
			prev_rx = rx;
			prev_ms = ms;

			limit = ms_sum * 64'd99;
			if (ms_sum == 0)
				rpt.lvl = LVL_CLEAN;
			else if (rx_sum > limit)
				rpt.lvl = LVL_MINOR;
			else
				rpt.lvl = LVL_SEVERE;

			next_rate = {32'b0, rate};
			if ((ms_sum == 0 && rx_sum != 0) || rx_sum < limit) begin
				if (ms_sum == 0)
					next_rate = (next_rate * 64'd11 + 64'd5) / 64'd10;
				else
					next_rate = (next_rate * 64'd9 + 64'd5) / 64'd10;
				floor_rate = {32'b0, max_rate} / 64'd1000;
				if (next_rate > {32'b0, max_rate})
					next_rate = {32'b0, max_rate};
				if (next_rate < floor_rate)
					next_rate = floor_rate;
			end
			rpt.recent_rx = rx_sum[OUT_SUM_W-1:0];
			rpt.recent_ms = ms_sum[OUT_SUM_W-1:0];
			rpt.rate = next_rate[CNT_W-1:0];
			rpt.changed = (next_rate != {32'b0, rate});
			pending_reports.push_back(rpt);
		endfunction

		function void match_report(logic [LVL_W-1:0] lvl, logic [OUT_SUM_W-1:0] recent_rx,
				logic [OUT_SUM_W-1:0] recent_ms, logic [CNT_W-1:0] rate, logic changed);
			report_t rpt;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("report with none pending: level %0d rate %0d", lvl, rate);
				return;
			end
			rpt = pending_reports.pop_front();
			if (lvl !== rpt.lvl || recent_rx !== rpt.recent_rx || recent_ms !== rpt.recent_ms
					|| rate !== rpt.rate || changed !== rpt.changed) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN) begin
					$write("report mismatch (exp/act): level %0d/%0d received %0d/%0d",
						rpt.lvl, lvl, rpt.recent_rx, recent_rx);
					$display(" missed %0d/%0d rate %0d/%0d changed %0d/%0d",
						rpt.recent_ms, recent_ms, rpt.rate, rate, rpt.changed, changed);
				end
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	logic             calm;
	logic [CNT_W-1:0] rx_total;
	logic [CNT_W-1:0] ms_total;
	logic [CNT_W-1:0] max_rate_now;
	int unsigned      cycle_count;
	health_scoreboard board;

	plra_req_if counts_if();
	plra_rpt_if report_if();

	packet_loss_rate_adapter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.counts    (counts_if),
		.report    (report_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("[packet_loss_rate_adapter_unit] ERROR");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [CNT_W-1:0] rx, input logic [CNT_W-1:0] ms,
			input logic [CNT_W-1:0] rate);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			counts_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		counts_if.valid <= 1'b1;
		counts_if.received_count <= rx;
		counts_if.missed_count <= ms;
		counts_if.current_rate <= rate;
		do @(posedge clk); while (!counts_if.ready);
		board.take_request(rx, ms, rate);
		rx_total = rx;
		ms_total = ms;
		if ($urandom_range(0, 39) == 0)
			calm = ~calm;
	endtask

	task automatic drain_reports();
		counts_if.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (REPORT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_max_rate(input logic [CNT_W-1:0] value);
		drain_reports();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.max_rate = value;
		max_rate_now = value;
		// hold off while the lower clamp follows the new limit
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [CNT_W-1:0] pick_rate();
		logic [63:0] near;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, max_rate_now);
			2: return max_rate_now - $urandom_range(0, 20);
			3: return $urandom_range(0, max_rate_now / 1000 * 2 + 10);
			4: return $urandom_range(0, 100);
			default: begin
				near = {32'b0, max_rate_now} * 64'd10 / 64'd11;
				return near[CNT_W-1:0] + $urandom_range(0, 3);
			end
		endcase
	endfunction

	task automatic random_request();
		logic [CNT_W-1:0] drx;
		logic [CNT_W-1:0] dms;
		int unsigned      pick;
		pick = $urandom_range(0, 19);
		if (pick <= 7) begin
			drx = $urandom_range(0, 2000);
			dms = 0;
		end else if (pick <= 11) begin
			dms = $urandom_range(1, 3);
			drx = 99 * dms + $urandom_range(1, 400);
		end else if (pick <= 14) begin
			dms = $urandom_range(1, 50);
			drx = $urandom_range(0, 99 * dms);
		end else if (pick == 15) begin
			dms = $urandom_range(1, 20);
			drx = 99 * dms;
		end else if (pick == 16) begin
			drx = 0;
			dms = 0;
		end else if (pick == 17) begin
			drx = $urandom;
			dms = $urandom_range(0, 1);
		end else begin
			// jump both counters anywhere
			drx = $urandom - rx_total;
			dms = $urandom - ms_total;
		end
		send_request(rx_total + drx, ms_total + dms, pick_rate());
	endtask

	initial begin
		report_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int unsigned gap;
			gap = calm ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				report_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			report_if.ready <= 1'b1;
			do @(posedge clk); while (!report_if.valid);
			board.match_report(report_if.health_level, report_if.recent_received,
				report_if.recent_missed, report_if.new_rate, report_if.rate_changed);
		end
	end

	initial begin
		logic [CNT_W-1:0] settings [5];
		board = new();
		calm = 1'b0;
		rx_total = '0;
		ms_total = '0;
		max_rate_now = MAX_RATE_RESET;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		counts_if.valid <= 1'b0;
		counts_if.received_count <= '0;
		counts_if.missed_count <= '0;
		counts_if.current_rate <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty window, then a ratio of exactly 99/100
		send_request(32'd0, 32'd0, 32'd1000);
		send_request(32'd99, 32'd1, 32'd1000);
		send_request(32'd99, 32'd1, 32'd2000);
		send_request(32'd199, 32'd1, 32'd5);
		send_request(32'd200, 32'd10, 32'hFFFF_FFFF);
		send_request(32'd210, 32'd10, 32'd0);
		// flush the misses out of the window
		send_request(32'd220, 32'd10, 32'd0);
		send_request(32'd230, 32'd10, 32'd1);
		send_request(32'd240, 32'd10, 32'd5);
		send_request(32'd250, 32'd10, MAX_RATE_RESET);
		send_request(32'd260, 32'd10, 32'hFFFF_FFFF);
		send_request(32'd270, 32'd10, 32'd12345);
		// received counter going backwards gives full-scale deltas
		send_request(32'd269, 32'd10, 32'd0);
		send_request(32'd268, 32'd10, 32'd7);
		send_request(32'd267, 32'd10, 32'd104545455);
		send_request(32'd266, 32'd10, 32'd104545454);
		send_request(32'd265, 32'd10, 32'h8000_0000);
		// missed counter wraps
		send_request(32'd300, 32'd9, 32'd1000);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
		send_request(32'd0, 32'd0, 32'h5555_5555);
		send_request(32'hFFFF_FFFF, 32'd0, 32'd115000);
		send_request(32'd0, 32'hFFFF_FFFF, 32'd115001);

		settings[0] = 32'd1000;
		settings[1] = 32'hFFFF_FFFF;
		settings[2] = 32'd500;
		settings[3] = $urandom_range(1000, 32'hFFFF_FFFF);
		settings[4] = MAX_RATE_RESET;
		for (int unsigned s = 0; s <= 5; s++) begin
			if (s != 0)
				write_max_rate(settings[s-1]);
			repeat (ITEMS_PER_SETTING) random_request();
		end

		drain_reports();
		if (board.mismatches == 0)
			$display("[packet_loss_rate_adapter_unit] OK");
		else
			$display("[packet_loss_rate_adapter_unit] ERROR");
		$finish;
	end

endmodule
